// File: design/mcpe_pkg.sv
// shared types, constants and saturating arithmetic for the max-cut evaluator
`default_nettype none
package mcpe_pkg;

  // sizing
  localparam int MAX_VERTICES = 1024;
  localparam int ACC_BITS     = 48;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int VX_W         = 10;
  localparam int W_W          = 32;
  localparam int OUT_W        = 48;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);

  // input function codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_CUT   = 2'd1;
  localparam logic [1:0] FUNC_NBR   = 2'd2;

  // membership codes
  localparam logic [1:0] MEM_NONE = 2'd0;
  localparam logic [1:0] MEM_S    = 2'd1;
  localparam logic [1:0] MEM_COMP = 2'd2;

  typedef logic signed [ACC_BITS-1:0] acc_t;
  typedef logic signed [W_W-1:0]      wgt_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  // operation classes carried through the queue
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_CUT,
    OP_NBR
  } op_e;

  // result kinds
  typedef enum logic {
    RES_CUT   = 1'b0,
    RES_SIGMA = 1'b1
  } res_e;

  // classified word as it sits in the queue
  typedef struct packed {
    op_e               kind;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              a_ok;
    logic              b_ok;
    logic [1:0]        code;
    wgt_t              weight;
    logic              last;
  } op_t;

  // accumulator plus a link weight, clamped to the accumulator range
  function automatic acc_t sat_add(acc_t acc, wgt_t w);
    logic signed [ACC_BITS:0] sum;
    acc_t                     res;
    sum = {acc[ACC_BITS-1], acc} + {{(ACC_BITS+1-W_W){w[W_W-1]}}, w};
    if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
      res = sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      res = sum[ACC_BITS-1:0];
    end
    return res;
  endfunction

  // difference of two accumulators, clamped
  function automatic acc_t sat_sub(acc_t a, acc_t b);
    logic signed [ACC_BITS:0] dif;
    acc_t                     res;
    dif = {a[ACC_BITS-1], a} - {b[ACC_BITS-1], b};
    if (dif[ACC_BITS] != dif[ACC_BITS-1]) begin
      res = dif[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      res = dif[ACC_BITS-1:0];
    end
    return res;
  endfunction

  // accumulator value to output field width
  function automatic logic [OUT_W-1:0] to_out(acc_t v);
    return OUT_W'(v);
  endfunction

endpackage
`default_nettype wire

// File: design/mcpe_front.sv
// front end: input handshake and classification of incoming words
`default_nettype none
module mcpe_front import mcpe_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       func_i,
  input  wire logic [VX_W-1:0]  vertex_a_i,
  input  wire logic [VX_W-1:0]  vertex_b_i,
  input  wire logic [W_W-1:0]   weight_i,
  input  wire logic [1:0]       member_i,
  input  wire logic             last_i,
  input  wire logic             clearing_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output op_t                   op_o
);

  logic accept;
  logic known;

  // take a word whenever the queue has room and the table is ready
  assign in_ready_o = !clearing_i && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // classify the word
  always_comb begin
    op_o        = '0;
    known       = 1'b1;
    op_o.addr_a = ADDR_W'(vertex_a_i);
    op_o.addr_b = ADDR_W'(vertex_b_i);
    op_o.a_ok   = 32'(vertex_a_i) < 32'(MAX_VERTICES);
    op_o.b_ok   = 32'(vertex_b_i) < 32'(MAX_VERTICES);
    op_o.weight = weight_i;
    op_o.last   = last_i;
    op_o.code   = (member_i inside {MEM_S, MEM_COMP}) ? member_i : MEM_NONE;
    case (func_i)
      FUNC_WRITE: op_o.kind = OP_WRITE;
      FUNC_CUT:   op_o.kind = OP_CUT;
      FUNC_NBR:   op_o.kind = OP_NBR;
      default: begin
        op_o.kind = OP_WRITE;
        known     = 1'b0;
      end
    endcase
  end

  // reserved function code is dropped here
  assign push_o = accept && known;

  ap_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_i |-> !push_o)
    else $error("word taken during table clear");

  ap_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full_i |-> !push_o)
    else $error("push into full queue");

  ap_reserved_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (func_i != FUNC_WRITE && func_i != FUNC_CUT && func_i != FUNC_NBR) |-> !push_o)
    else $error("reserved function word entered the queue");

endmodule
`default_nettype wire

// File: design/mcpe_queue.sv
// short queue between the classifier and the execution pipeline
`default_nettype none
module mcpe_queue import mcpe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  input  wire logic pop_i,
  output op_t       op_o,
  output logic      full_o,
  output logic      empty_o
);

  op_t               slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == (QPTR_W+1)'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = slot_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count past depth");

  ap_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QPTR_W'(wr_ptr_q - rd_ptr_q) == QPTR_W'(cnt_q))
    else $error("queue pointers disagree with count");

  ap_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: design/mcpe_back.sv
// execution pipeline: membership table, accumulators, delta and result register
`default_nettype none
module mcpe_back import mcpe_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire op_t               op_i,
  input  wire logic              q_empty_i,
  output logic                   pop_o,
  output logic                   clearing_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   kind_o,
  output logic [OUT_W-1:0]       cut_weight_o,
  output logic [OUT_W-1:0]       sigma_in_s_o,
  output logic [OUT_W-1:0]       sigma_in_comp_o,
  output logic [OUT_W-1:0]       move_delta_o
);

  // membership table and clear sweep
  logic [1:0]        membership_q [MAX_VERTICES];
  logic              clearing_q, clearing_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [1:0]        rd_a_q, rd_b_q;

  // stage two: table codes back, accumulate
  logic              v2_q, v2_d;
  op_e               kind2_q;
  logic              last2_q, a_ok2_q, b_ok2_q;
  wgt_t              w2_q;
  acc_t              cut_sum_q, cut_sum_d;
  acc_t              s_sum_q, s_sum_d;
  acc_t              comp_sum_q, comp_sum_d;
  logic [1:0]        code_a, code_b;
  acc_t              cut_new, s_new, comp_new;

  // stage three: finished run, delta
  logic              v3_q, v3_d;
  res_e              kind3_q;
  acc_t              sum_a3_q, sum_b3_q;
  logic              a_in3_q;
  acc_t              delta;
  logic              load3;

  // result register
  logic              out_valid_q, out_valid_d;
  res_e              kind_q;
  logic [OUT_W-1:0]  cut_q, s_q, comp_q, delta_q;

  logic adv;

  // whole pipeline holds while a result waits on a stalled consumer
  assign adv        = !out_valid_q || out_ready_i;
  assign pop_o      = adv && !q_empty_i && !clearing_q;
  assign clearing_o = clearing_q;

  // clear sweep over the table after reset
  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == ADDR_W'(MAX_VERTICES - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  // table write and the two registered reads
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      membership_q[clr_cnt_q] <= MEM_NONE;
    end else if (pop_o && op_i.kind == OP_WRITE && op_i.a_ok) begin
      membership_q[op_i.addr_a] <= op_i.code;
    end
    if (pop_o) begin
      rd_a_q <= membership_q[op_i.addr_a];
      rd_b_q <= membership_q[op_i.addr_b];
    end
  end

  // stage two payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind2_q <= op_i.kind;
      last2_q <= op_i.last;
      a_ok2_q <= op_i.a_ok;
      b_ok2_q <= op_i.b_ok;
      w2_q    <= op_i.weight;
    end
  end

  assign v2_d = adv ? (pop_o && op_i.kind != OP_WRITE) : v2_q;

  // saturating accumulate
  always_comb begin
    code_a   = a_ok2_q ? rd_a_q : MEM_NONE;
    code_b   = b_ok2_q ? rd_b_q : MEM_NONE;
    cut_new  = ((code_a == MEM_S) != (code_b == MEM_S)) ? sat_add(cut_sum_q, w2_q)
                                                        : cut_sum_q;
    s_new    = (code_b == MEM_S) ? sat_add(s_sum_q, w2_q) : s_sum_q;
    comp_new = (code_b == MEM_COMP) ? sat_add(comp_sum_q, w2_q) : comp_sum_q;
  end

  always_comb begin
    cut_sum_d  = cut_sum_q;
    s_sum_d    = s_sum_q;
    comp_sum_d = comp_sum_q;
    if (adv && v2_q) begin
      case (kind2_q)
        OP_CUT: begin
          cut_sum_d = last2_q ? '0 : cut_new;
        end
        OP_NBR: begin
          s_sum_d    = last2_q ? '0 : s_new;
          comp_sum_d = last2_q ? '0 : comp_new;
        end
        default: begin
          cut_sum_d = cut_sum_q;
        end
      endcase
    end
  end

  // hand a finished run to stage three
  assign load3 = adv && v2_q && last2_q;
  assign v3_d  = adv ? (v2_q && last2_q) : v3_q;

  always_ff @(posedge clk_i) begin
    if (load3) begin
      kind3_q  <= (kind2_q == OP_CUT) ? RES_CUT : RES_SIGMA;
      sum_a3_q <= (kind2_q == OP_CUT) ? cut_new : s_new;
      sum_b3_q <= comp_new;
      a_in3_q  <= code_a == MEM_S;
    end
  end

  // move gain
  assign delta = a_in3_q ? sat_sub(sum_a3_q, sum_b3_q) : sat_sub(sum_b3_q, sum_a3_q);

  // result register
  assign out_valid_d = adv ? v3_q : out_valid_q;

  always_ff @(posedge clk_i) begin
    if (adv && v3_q) begin
      kind_q <= kind3_q;
      if (kind3_q == RES_CUT) begin
        cut_q   <= to_out(sum_a3_q);
        s_q     <= '0;
        comp_q  <= '0;
        delta_q <= '0;
      end else begin
        cut_q   <= '0;
        s_q     <= to_out(sum_a3_q);
        comp_q  <= to_out(sum_b3_q);
        delta_q <= to_out(delta);
      end
    end
  end

  // control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      cut_sum_q   <= '0;
      s_sum_q     <= '0;
      comp_sum_q  <= '0;
    end else begin
      clearing_q  <= clearing_d;
      clr_cnt_q   <= clr_cnt_d;
      v2_q        <= v2_d;
      v3_q        <= v3_d;
      out_valid_q <= out_valid_d;
      cut_sum_q   <= cut_sum_d;
      s_sum_q     <= s_sum_d;
      comp_sum_q  <= comp_sum_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign cut_weight_o    = cut_q;
  assign sigma_in_s_o    = s_q;
  assign sigma_in_comp_o = comp_q;
  assign move_delta_o    = delta_q;

  ap_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !pop_o)
    else $error("queue popped during table clear");

  ap_cut_cleared_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v2_q && last2_q && kind2_q == OP_CUT) |=> cut_sum_q == '0)
    else $error("cut accumulator not cleared after run");

  ap_cut_result_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == RES_CUT) |-> (s_q == '0 && comp_q == '0 && delta_q == '0))
    else $error("cut result carries sigma fields");

  ap_sigma_result_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == RES_SIGMA) |-> cut_q == '0)
    else $error("sigma result carries cut field");

endmodule
`default_nettype wire

// File: design/max_cut_partition_evaluator.sv
// top level of the max-cut partition evaluator
//
// channel | dir | handshake            | payload
// input   | in  | in_valid_i/in_ready_o | func, vertex_a, vertex_b, weight, member, last
// output  | out | out_valid_o/out_ready_i | kind, cut_weight, sigma_in_s, sigma_in_comp, move_delta
//
// one word accepted per cycle while the queue has room and no table clear runs; the last
// word of a run passes the queue, the table read, the accumulate stage and the delta stage
// after reset all MAX_VERTICES (1024) entries of the membership table are swept to zero,
// with in_ready_o low for the whole sweep
// a stalled output freezes the execution pipeline; the four-entry queue keeps
// taking words until it fills
`default_nettype none
module max_cut_partition_evaluator import mcpe_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       func_i,
  input  wire logic [VX_W-1:0]  vertex_a_i,
  input  wire logic [VX_W-1:0]  vertex_b_i,
  input  wire logic [W_W-1:0]   weight_i,
  input  wire logic [1:0]       member_i,
  input  wire logic             last_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  kind_o,
  output logic [OUT_W-1:0]      cut_weight_o,
  output logic [OUT_W-1:0]      sigma_in_s_o,
  output logic [OUT_W-1:0]      sigma_in_comp_o,
  output logic [OUT_W-1:0]      move_delta_o
);

  op_t  push_op, head_op;
  logic push, pop, q_full, q_empty, clearing;

  // classifier
  mcpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .vertex_a_i (vertex_a_i),
    .vertex_b_i (vertex_b_i),
    .weight_i   (weight_i),
    .member_i   (member_i),
    .last_i     (last_i),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .push_o     (push),
    .op_o       (push_op)
  );

  // decoupling queue
  mcpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .op_o    (head_op),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // execution pipeline
  mcpe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (head_op),
    .q_empty_i       (q_empty),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .cut_weight_o    (cut_weight_o),
    .sigma_in_s_o    (sigma_in_s_o),
    .sigma_in_comp_o (sigma_in_comp_o),
    .move_delta_o    (move_delta_o)
  );

endmodule
`default_nettype wire

// File: tb/max_cut_partition_evaluator_tb.sv
// testbench for the max-cut partition evaluator: directed table, random runs, idle-free tail
`timescale 1ns / 100ps
module max_cut_partition_evaluator_tb;
  import mcpe_pkg::*;

  // codes the package leaves out
  localparam logic [1:0] FUNC_IGNORED = 2'd3;
  localparam logic [1:0] MEM_BAD      = 2'd3;

  localparam int unsigned RANDOM_WORDS  = 950;
  localparam int unsigned TAIL_LEN      = 16;
  localparam int unsigned HALF_TAIL_LEN = 8;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam wgt_t        W_MAX         = 32'sh7fff_ffff;
  localparam wgt_t        W_MIN         = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]      func;
    logic [VX_W-1:0] va;
    logic [VX_W-1:0] vb;
    wgt_t            weight;
    logic [1:0]      member;
    logic            last;
  } word_t;

  typedef struct packed {
    res_e kind;
    acc_t cut;
    acc_t s;
    acc_t comp;
    acc_t delta;
  } result_t;

  // one row of stimulus, optionally with its result typed in
  typedef struct packed {
    word_t   w;
    bit      fixed;
    result_t r;
  } step_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             in_valid_i      = 1'b0;
  logic             in_ready_o;
  logic [1:0]       func_i          = '0;
  logic [VX_W-1:0]  vertex_a_i      = '0;
  logic [VX_W-1:0]  vertex_b_i      = '0;
  logic [W_W-1:0]   weight_i        = '0;
  logic [1:0]       member_i        = '0;
  logic             last_i          = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i     = 1'b0;
  logic             kind_o;
  logic [OUT_W-1:0] cut_weight_o;
  logic [OUT_W-1:0] sigma_in_s_o;
  logic [OUT_W-1:0] sigma_in_comp_o;
  logic [OUT_W-1:0] move_delta_o;

  // predictor state
  logic [1:0]  side_of [MAX_VERTICES];
  acc_t        cut_total;
  acc_t        s_total;
  acc_t        comp_total;
  result_t     pending_results [$];

  bit          quiet        = 1'b0;
  int unsigned words_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;

  max_cut_partition_evaluator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .vertex_a_i      (vertex_a_i),
    .vertex_b_i      (vertex_b_i),
    .weight_i        (weight_i),
    .member_i        (member_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .cut_weight_o    (cut_weight_o),
    .sigma_in_s_o    (sigma_in_s_o),
    .sigma_in_comp_o (sigma_in_comp_o),
    .move_delta_o    (move_delta_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // clamp a wide sum into the accumulator range
  function automatic acc_t clamp_acc(longint v);
    if (v > longint'(ACC_MAX)) return ACC_MAX;
    if (v < longint'(ACC_MIN)) return ACC_MIN;
    return acc_t'(v);
  endfunction

  // apply one accepted word to the partition state, return 1 when it closes a run
  function automatic bit apply_word(word_t w, output result_t r);
    logic [1:0] code_a;
    logic [1:0] code_b;
    r = '0;
    code_a = side_of[w.va];
    code_b = side_of[w.vb];
    case (w.func)
      FUNC_WRITE: side_of[w.va] = (w.member == MEM_BAD) ? MEM_NONE : w.member;
      FUNC_CUT: begin
        // edge counts only when exactly one endpoint sits in S
        if ((code_a == MEM_S) != (code_b == MEM_S))
          cut_total = clamp_acc(longint'(cut_total) + longint'($signed(w.weight)));
        if (w.last) begin
          r.kind = RES_CUT;
          r.cut = cut_total;
          cut_total = '0;
          return 1'b1;
        end
      end
      FUNC_NBR: begin
        if (code_b == MEM_S)
          s_total = clamp_acc(longint'(s_total) + longint'($signed(w.weight)));
        else if (code_b == MEM_COMP)
          comp_total = clamp_acc(longint'(comp_total) + longint'($signed(w.weight)));
        if (w.last) begin
          r.kind = RES_SIGMA;
          r.s = s_total;
          r.comp = comp_total;
          // vertex outside S takes the complement-side gain
          if (code_a == MEM_S)
            r.delta = clamp_acc(longint'(s_total) - longint'(comp_total));
          else
            r.delta = clamp_acc(longint'(comp_total) - longint'(s_total));
          s_total = '0;
          comp_total = '0;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic step_t row(logic [1:0] func, int va, int vb, wgt_t wt,
                                logic [1:0] mem, bit last);
    step_t st;
    st = '0;
    st.w.func = func;
    st.w.va = VX_W'(va);
    st.w.vb = VX_W'(vb);
    st.w.weight = wt;
    st.w.member = mem;
    st.w.last = last;
    return st;
  endfunction

  function automatic step_t with_cut(step_t st, acc_t cut);
    st.fixed = 1'b1;
    st.r = '0;
    st.r.kind = RES_CUT;
    st.r.cut = cut;
    return st;
  endfunction

  function automatic step_t with_sigma(step_t st, acc_t s, acc_t comp, acc_t delta);
    st.fixed = 1'b1;
    st.r = '0;
    st.r.kind = RES_SIGMA;
    st.r.s = s;
    st.r.comp = comp;
    st.r.delta = delta;
    return st;
  endfunction

  // append a row to a stimulus table
  function automatic void add_row(ref step_t rows [$], input step_t st);
    rows.insert(rows.size(), st);
  endfunction

  // mostly a small vertex pool so memberships matter, sometimes anywhere
  function automatic int pick_vertex();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, MAX_VERTICES - 1);
    return $urandom_range(0, 31);
  endfunction

  function automatic wgt_t pick_weight();
    wgt_t wt;
    case ($urandom_range(0, 7))
      0: wt = W_MAX;
      1: wt = W_MIN;
      2: wt = wgt_t'(int'($urandom_range(0, 200)) - 100);
      default: wt = wgt_t'($urandom());
    endcase
    return wt;
  endfunction

  // drive one word, wait for its handshake, then predict
  task automatic send_step(step_t st);
    result_t r;
    bit      has_res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= st.w.func;
    vertex_a_i <= st.w.va;
    vertex_b_i <= st.w.vb;
    weight_i   <= st.w.weight;
    member_i   <= st.w.member;
    last_i     <= st.w.last;
    do @(posedge clk_i); while (!in_ready_o);
    has_res = apply_word(st.w, r);
    if (has_res) pending_results.insert(pending_results.size(), st.fixed ? st.r : r);
    if (st.w.func != FUNC_IGNORED) words_sent++;
  endtask

  // hold off the sender until every outstanding result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic void check_field(string name, acc_t want, logic [OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, $signed(got));
      mismatches++;
    end
  endfunction

  // output stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: kind %0d", kind_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          mismatches++;
        end
        check_field("cut_weight", want.cut, cut_weight_o);
        check_field("sigma_in_s", want.s, sigma_in_s_o);
        check_field("sigma_in_comp", want.comp, sigma_in_comp_o);
        check_field("move_delta", want.delta, move_delta_o);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    step_t stim_table [$];
    int    i;
    int    len;
    int    anchor;
    int    cut_left;
    int    nbr_left;

    foreach (side_of[v]) side_of[v] = MEM_NONE;
    cut_total = '0;
    s_total = '0;
    comp_total = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows: nothing in S after reset, then rails and special codes
    add_row(stim_table, with_cut(row(FUNC_CUT, 0, 1023, 5, MEM_NONE, 1'b1), '0));
    add_row(stim_table, with_sigma(row(FUNC_NBR, 1023, 0, 7, MEM_NONE, 1'b1),
                                   '0, '0, '0));
    add_row(stim_table, row(FUNC_WRITE, 0, 0, 0, MEM_S, 1'b0));
    add_row(stim_table, row(FUNC_WRITE, 1023, 1023, -1, MEM_COMP, 1'b1));
    add_row(stim_table, row(FUNC_WRITE, 5, 0, 0, MEM_BAD, 1'b0));
    add_row(stim_table, row(FUNC_WRITE, 1, 0, 0, MEM_COMP, 1'b0));
    add_row(stim_table, with_cut(row(FUNC_CUT, 0, 1023, W_MAX, MEM_NONE, 1'b1),
                                 acc_t'(W_MAX)));
    add_row(stim_table, with_cut(row(FUNC_CUT, 1023, 0, W_MIN, MEM_NONE, 1'b1),
                                 acc_t'(W_MIN)));
    add_row(stim_table, with_sigma(row(FUNC_NBR, 0, 1023, W_MIN, MEM_NONE, 1'b1),
                                   '0, acc_t'(W_MIN), acc_t'(48'sd2147483648)));
    // interleaved cut and neighbour runs, neither-set vertex 5
    add_row(stim_table, row(FUNC_CUT, 0, 5, -1, MEM_NONE, 1'b0));
    add_row(stim_table, row(FUNC_CUT, 1, 1023, 100, MEM_S, 1'b0));
    add_row(stim_table, row(FUNC_NBR, 0, 1023, W_MAX, MEM_NONE, 1'b0));
    add_row(stim_table, row(FUNC_NBR, 0, 5, 9, MEM_COMP, 1'b0));
    add_row(stim_table, row(FUNC_CUT, 0, 0, 3, MEM_NONE, 1'b1));
    add_row(stim_table, row(FUNC_NBR, 0, 0, 12345, MEM_NONE, 1'b1));
    add_row(stim_table, row(FUNC_IGNORED, 0, 1, 55, MEM_S, 1'b1));
    add_row(stim_table, row(FUNC_NBR, 5, 0, 10, MEM_NONE, 1'b0));
    add_row(stim_table, row(FUNC_NBR, 5, 1, 20, MEM_NONE, 1'b1));
    add_row(stim_table, row(FUNC_NBR, 1, 0, -1, MEM_NONE, 1'b1));
    add_row(stim_table, row(FUNC_WRITE, 0, 0, 0, MEM_NONE, 1'b1));
    add_row(stim_table, with_cut(row(FUNC_CUT, 0, 1, 1, MEM_NONE, 1'b1), '0));
    add_row(stim_table, with_sigma(row(FUNC_NBR, 0, 0, 4, MEM_NONE, 1'b1),
                                   '0, '0, '0));
    foreach (stim_table[k]) send_step(stim_table[k]);
    wait_drained();

    // random runs
    while (words_sent < stim_table.size() + RANDOM_WORDS) begin
      quiet = ($urandom_range(0, 3) == 0);
      len = $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 6))
            send_step(row(FUNC_WRITE, pick_vertex(), pick_vertex(), pick_weight(),
                          2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
        end
        2, 3, 4: begin
          for (i = 1; i <= len; i++)
            send_step(row(FUNC_CUT, pick_vertex(), pick_vertex(), pick_weight(),
                          2'($urandom_range(0, 3)), i == len));
        end
        5, 6, 7: begin
          anchor = pick_vertex();
          for (i = 1; i <= len; i++)
            send_step(row(FUNC_NBR, anchor, pick_vertex(), pick_weight(),
                          2'($urandom_range(0, 3)), i == len));
        end
        8: begin
          // both kinds of run open at once
          anchor = pick_vertex();
          cut_left = len;
          nbr_left = $urandom_range(1, 12);
          while (cut_left + nbr_left > 0) begin
            if (nbr_left == 0 || (cut_left != 0 && $urandom_range(0, 1) == 0)) begin
              cut_left--;
              send_step(row(FUNC_CUT, pick_vertex(), pick_vertex(), pick_weight(),
                            2'($urandom_range(0, 3)), cut_left == 0));
            end else begin
              nbr_left--;
              send_step(row(FUNC_NBR, anchor, pick_vertex(), pick_weight(),
                            2'($urandom_range(0, 3)), nbr_left == 0));
            end
          end
        end
        default: begin
          // noise, including the unused function code
          repeat ($urandom_range(1, 3))
            send_step(row(2'($urandom_range(0, 3)), $urandom_range(0, MAX_VERTICES - 1),
                          $urandom_range(0, MAX_VERTICES - 1), wgt_t'($urandom()),
                          2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
        end
      endcase
    end
    wait_drained();

    // back-to-back tail near the weight rails, no idling from here on
    quiet = 1'b1;
    send_step(row(FUNC_WRITE, 0, 0, 0, MEM_S, 1'b0));
    send_step(row(FUNC_WRITE, 1, 0, 0, MEM_COMP, 1'b0));
    // crossing edges at the top rail
    for (i = 1; i <= TAIL_LEN; i++)
      send_step(row(FUNC_CUT, 0, 1, W_MAX, MEM_NONE, i == TAIL_LEN));
    // sigma sums on opposite rails interleaved with a low-rail cut run
    for (i = 0; i < TAIL_LEN; i++) begin
      send_step(row(FUNC_NBR, 1, 0, W_MAX, MEM_NONE, 1'b0));
      send_step(row(FUNC_NBR, 1, 1, W_MIN, MEM_NONE, 1'b0));
      send_step(row(FUNC_CUT, 1, 0, W_MIN, MEM_NONE, 1'b0));
    end
    send_step(row(FUNC_CUT, 1, 1, 0, MEM_NONE, 1'b1));
    send_step(row(FUNC_NBR, 1, 1, 0, MEM_NONE, 1'b1));
    // vertex in S with both sums growing apart
    for (i = 0; i < HALF_TAIL_LEN; i++) begin
      send_step(row(FUNC_NBR, 0, 0, W_MAX, MEM_NONE, 1'b0));
      send_step(row(FUNC_NBR, 0, 1, W_MIN, MEM_NONE, 1'b0));
    end
    send_step(row(FUNC_NBR, 0, 0, 0, MEM_NONE, 1'b1));

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
